FILE: rtl/fixed_slot_pool_allocator_defines.svh
// assertion macros shared by the checker
`ifndef FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_POOL_ALLOCATOR_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define FSPA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fspa checker: same-cycle property failed");

// antecedent implies consequent in the next cycle
`define FSPA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fspa checker: next-cycle property failed");

`endif

FILE: rtl/fspa_pkg.sv
`timescale 1ns / 1ps

package fspa_pkg;

    localparam int ADDR_W        = 32;
    localparam int KIND_W        = 2;
    localparam int STATUS_W      = 2;
    localparam int CNT_W         = 9;
    localparam int LOG2_W        = 5;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int MIN_SLOT_LOG2 = 2;

    localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REINIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FOREIGN   = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE_USED = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_ADDRESS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_SIZE_LOG2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT     = 2'd2;

    localparam logic [ADDR_W-1:0] RESET_BASE_ADDRESS   = '0;
    localparam logic [LOG2_W-1:0] RESET_SLOT_SIZE_LOG2 = 5'd2;
    localparam logic [CNT_W-1:0]  RESET_SLOT_COUNT     = 9'd256;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ADDR_W-1:0] address;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   slot_address;
        logic [CNT_W-1:0]    in_use_count;
    } rsp_t;

endpackage

FILE: rtl/fspa_ring.sv
`timescale 1ns / 1ps

module fspa_ring #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_idx,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_idx,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/fixed_slot_pool_allocator.sv
`timescale 1ns / 1ps
// channel    | handshake          | payload
// -----------+--------------------+-------------------------------
// request    | start, busy        | cmd (kind, address)
// result     | done               | rsp (status, slot_address, in_use_count)
// config     | cfg_we             | cfg_index, cfg_data
//
// one request accepted per cycle; busy stays low
// each result appears in the cycle after its request; the released-address
// ring memory has a registered read port
// reset clears counters and ring pointers and loads register defaults;
// ring entries are read only after they were written, so no clearing pass
// the receiver cannot stall: every done pulse is one result beat

module fixed_slot_pool_allocator #(
    parameter int MAX_SLOTS = 256
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  fspa_pkg::cmd_t                  cmd,
    output logic                            done,
    output fspa_pkg::rsp_t                  rsp,
    input  logic                            cfg_we,
    input  logic [fspa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fspa_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W  = $clog2(MAX_SLOTS);
    localparam int FILL_W = $clog2(MAX_SLOTS + 1);
    localparam int CAP    = (MAX_SLOTS > 511) ? 511 : MAX_SLOTS;
    localparam int LIM_W  = fspa_pkg::ADDR_W + fspa_pkg::CNT_W;

    localparam logic [PTR_W-1:0]            PTR_LAST  = PTR_W'(MAX_SLOTS - 1);
    localparam logic [FILL_W-1:0]           FILL_FULL = FILL_W'(MAX_SLOTS);
    localparam logic [fspa_pkg::CNT_W-1:0]  COUNT_CAP = fspa_pkg::CNT_W'(CAP);
    localparam logic [fspa_pkg::LOG2_W-1:0] LOG2_MIN  =
        fspa_pkg::LOG2_W'(fspa_pkg::MIN_SLOT_LOG2);

    logic [fspa_pkg::ADDR_W-1:0] base_reg;
    logic [fspa_pkg::LOG2_W-1:0] log2_reg;
    logic [fspa_pkg::CNT_W-1:0]  count_cfg_reg;

    logic [PTR_W-1:0]           head_reg, head_next;
    logic [PTR_W-1:0]           tail_reg, tail_next;
    logic [FILL_W-1:0]          fill_reg, fill_next;
    logic [fspa_pkg::CNT_W-1:0] fresh_reg, fresh_next;
    logic [fspa_pkg::CNT_W-1:0] alloc_reg, alloc_next;

    logic                          done_reg;
    logic [fspa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [fspa_pkg::ADDR_W-1:0]   fresh_addr_reg, fresh_addr_next;
    logic                          from_ring_reg, from_ring_next;
    logic [fspa_pkg::CNT_W-1:0]    in_use_reg;

    logic                          accept;
    logic [fspa_pkg::CNT_W-1:0]    eff_count;
    logic [fspa_pkg::LOG2_W-1:0]   eff_log2;
    logic [fspa_pkg::ADDR_W-1:0]   fresh_addr;
    logic [fspa_pkg::ADDR_W-1:0]   offset;
    logic [LIM_W-1:0]              limit;
    logic                          in_range;

    logic                          ring_wr_en;
    logic                          ring_rd_en;
    logic [fspa_pkg::ADDR_W-1:0]   ring_rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        eff_count  = (count_cfg_reg > COUNT_CAP) ? COUNT_CAP : count_cfg_reg;
        eff_log2   = (log2_reg < LOG2_MIN) ? LOG2_MIN : log2_reg;
        fresh_addr = base_reg + (fspa_pkg::ADDR_W'(fresh_reg) << eff_log2);
        offset     = cmd.address - base_reg;
        limit      = LIM_W'(eff_count - fspa_pkg::CNT_W'(1)) << eff_log2;
        in_range   = (eff_count != '0) && (LIM_W'(offset) <= limit);
    end

    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        fill_next       = fill_reg;
        fresh_next      = fresh_reg;
        alloc_next      = alloc_reg;
        status_next     = fspa_pkg::STATUS_OK;
        fresh_addr_next = '0;
        from_ring_next  = 1'b0;
        ring_wr_en      = 1'b0;
        ring_rd_en      = 1'b0;
        if (accept)
        begin
            case (cmd.kind)
                fspa_pkg::KIND_ALLOC:
                begin
                    if (alloc_reg >= eff_count)
                    begin
                        status_next = fspa_pkg::STATUS_EXHAUSTED;
                    end
                    else if (fresh_reg < eff_count)
                    begin
                        fresh_addr_next = fresh_addr;
                        fresh_next      = fresh_reg + fspa_pkg::CNT_W'(1);
                        alloc_next      = alloc_reg + fspa_pkg::CNT_W'(1);
                    end
                    else if (fill_reg != '0)
                    begin
                        ring_rd_en     = 1'b1;
                        from_ring_next = 1'b1;
                        head_next      = (head_reg == PTR_LAST) ? '0
                                                               : head_reg + PTR_W'(1);
                        fill_next      = fill_reg - FILL_W'(1);
                        alloc_next     = alloc_reg + fspa_pkg::CNT_W'(1);
                    end
                    else
                    begin
                        status_next = fspa_pkg::STATUS_EXHAUSTED;
                    end
                end
                fspa_pkg::KIND_RELEASE:
                begin
                    if (!in_range)
                    begin
                        status_next = fspa_pkg::STATUS_FOREIGN;
                    end
                    else if (alloc_reg == '0)
                    begin
                        status_next = fspa_pkg::STATUS_NONE_USED;
                    end
                    else
                    begin
                        // full ring drops the address, count still goes down
                        if (fill_reg < FILL_FULL)
                        begin
                            ring_wr_en = 1'b1;
                            tail_next  = (tail_reg == PTR_LAST) ? '0
                                                               : tail_reg + PTR_W'(1);
                            fill_next  = fill_reg + FILL_W'(1);
                        end
                        alloc_next = alloc_reg - fspa_pkg::CNT_W'(1);
                    end
                end
                fspa_pkg::KIND_REINIT:
                begin
                    head_next  = '0;
                    tail_next  = '0;
                    fill_next  = '0;
                    fresh_next = '0;
                    alloc_next = '0;
                end
                default:
                begin
                    status_next = fspa_pkg::STATUS_OK;
                end
            endcase
        end
    end

    fspa_ring #(
        .DEPTH (MAX_SLOTS),
        .WIDTH (fspa_pkg::ADDR_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr_en),
        .wr_idx  (tail_reg),
        .wr_data (cmd.address),
        .rd_en   (ring_rd_en),
        .rd_idx  (head_reg),
        .rd_data (ring_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= fspa_pkg::RESET_BASE_ADDRESS;
            log2_reg      <= fspa_pkg::RESET_SLOT_SIZE_LOG2;
            count_cfg_reg <= fspa_pkg::RESET_SLOT_COUNT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fspa_pkg::REG_BASE_ADDRESS:
                begin
                    base_reg <= cfg_data[fspa_pkg::ADDR_W-1:0];
                end
                fspa_pkg::REG_SLOT_SIZE_LOG2:
                begin
                    log2_reg <= cfg_data[fspa_pkg::LOG2_W-1:0];
                end
                fspa_pkg::REG_SLOT_COUNT:
                begin
                    count_cfg_reg <= cfg_data[fspa_pkg::CNT_W-1:0];
                end
                default:
                begin
                    base_reg <= base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            fresh_reg <= '0;
            alloc_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            fresh_reg <= fresh_next;
            alloc_reg <= alloc_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg     <= status_next;
            fresh_addr_reg <= fresh_addr_next;
            from_ring_reg  <= from_ring_next;
            in_use_reg     <= alloc_next;
        end
    end

    assign done              = done_reg;
    assign rsp.status        = status_reg;
    assign rsp.slot_address  = from_ring_reg ? ring_rd_data : fresh_addr_reg;
    assign rsp.in_use_count  = in_use_reg;

endmodule

FILE: rtl/fspa_checker.sv
`timescale 1ns / 1ps
`include "fixed_slot_pool_allocator_defines.svh"

module fspa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input fspa_pkg::cmd_t cmd,
    input logic           done,
    input fspa_pkg::rsp_t rsp
);

    // every accepted request gives one result beat in the next cycle
    `FSPA_ASSERT_NEXT(a_req_gives_beat, start && !busy, done)

    // no result beat without a request the cycle before
    `FSPA_ASSERT_NOW(a_beat_has_req, done, $past(start && !busy))

    // only a successful beat carries an address
    `FSPA_ASSERT_NOW(a_fail_zero_addr, done && rsp.status != fspa_pkg::STATUS_OK,
        rsp.slot_address == '0)

    // a reinit empties the pool
    `FSPA_ASSERT_NOW(a_reinit_empty, done && $past(cmd.kind) == fspa_pkg::KIND_REINIT,
        rsp.in_use_count == '0 && rsp.status == fspa_pkg::STATUS_OK)

    // exhaustion is only reported for allocate
    `FSPA_ASSERT_NOW(a_exhaust_alloc, done && rsp.status == fspa_pkg::STATUS_EXHAUSTED,
        $past(cmd.kind) == fspa_pkg::KIND_ALLOC)

endmodule

bind fixed_slot_pool_allocator fspa_checker u_fspa_checker (.*);
